@@ hdl/evss_pkg.sv @@
// ----------------------------------------------------------------------------
// evss_pkg
// Shared types, register indexes and defaults for the energy based voice
// activity detector and speech segmenter.
// ----------------------------------------------------------------------------
package evss_pkg;

   // default sizing of the frame and of the segment counters
   localparam int MAX_FRAME_DEF  = 4096;
   localparam int COUNT_BITS_DEF = 24;

   // fixed field widths
   localparam int SAMPLE_BITS    = 16;
   localparam int THRESH_BITS    = 15;
   localparam int THRESH_SQ_BITS = 2 * THRESH_BITS;
   localparam int SQ_BITS        = 31;
   localparam int CFG_COUNT_BITS = 24;
   localparam int CSR_INDEX_BITS = 3;

   // reset values of the configuration registers
   localparam logic [THRESH_BITS-1:0]    THRESH_RESET    = THRESH_BITS'(328);
   localparam logic [THRESH_SQ_BITS-1:0] THRESH_SQ_RESET = THRESH_SQ_BITS'(328 * 328);
   localparam logic [CFG_COUNT_BITS-1:0] SILENCE_RESET   = CFG_COUNT_BITS'(48000);
   localparam logic [CFG_COUNT_BITS-1:0] MIN_SEG_RESET   = CFG_COUNT_BITS'(24000);

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_DETECTOR_ENABLED = 3'd0,
      REG_CHANNEL_COUNT    = 3'd1,
      REG_ENERGY_THRESHOLD = 3'd2,
      REG_SILENCE_LIMIT    = 3'd3,
      REG_MIN_SEGMENT      = 3'd4
   } reg_index_type;

   // segment event codes
   typedef enum logic [1:0] {
      EVENT_NONE      = 2'd0,
      EVENT_ACCEPTED  = 2'd1,
      EVENT_DISCARDED = 2'd2
   } seg_event_type;

   // channel payloads
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_first;
      logic signed [SAMPLE_BITS-1:0] sample_second;
      logic                          frame_last;
   } req_payload_type;

   typedef struct packed {
      logic                      frame_is_speech;
      logic [1:0]                segment_event;
      logic [CFG_COUNT_BITS-1:0] segment_samples;
      logic                      segment_open;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CFG_COUNT_BITS-1:0] value;
   } csr_payload_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic                      detector_enabled;
      logic [1:0]                channel_count;
      logic [THRESH_SQ_BITS-1:0] threshold_sq;
      logic [CFG_COUNT_BITS-1:0] silence_limit;
      logic [CFG_COUNT_BITS-1:0] min_segment;
   } cfg_type;

endpackage

@@ hdl/evss_if.sv @@
// ----------------------------------------------------------------------------
// evss channel interfaces
// Valid/ready channels for sample requests, frame results and register writes.
// ----------------------------------------------------------------------------
interface evss_req_if import evss_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface evss_rsp_if import evss_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface evss_csr_if import evss_pkg::*; ();
   logic            valid;
   logic            ready;
   csr_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/evss_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// evss_cfg_regs
// Configuration registers; the energy threshold is squared as it is written.
// ----------------------------------------------------------------------------
module evss_cfg_regs import evss_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_valid,
   input  csr_payload_type wr_data,
   output logic            wr_ready,
   output cfg_type         cfg
);

   cfg_type                   cfg_ff;
   cfg_type                   cfg_in;
   logic [THRESH_BITS-1:0]    thresh;
   logic [THRESH_SQ_BITS-1:0] thresh_sq;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   // threshold square, one multiply ahead of the register
   always_comb begin
      thresh    = wr_data.value[THRESH_BITS-1:0];
      thresh_sq = thresh * thresh;
   end

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (reg_index_type'(wr_data.index))
            REG_DETECTOR_ENABLED: cfg_in.detector_enabled = wr_data.value[0];
            REG_CHANNEL_COUNT:    cfg_in.channel_count    = wr_data.value[1:0];
            REG_ENERGY_THRESHOLD: cfg_in.threshold_sq     = thresh_sq;
            REG_SILENCE_LIMIT:    cfg_in.silence_limit    = wr_data.value;
            REG_MIN_SEGMENT:      cfg_in.min_segment      = wr_data.value;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detector_enabled <= 1'b1;
         cfg_ff.channel_count    <= 2'd1;
         cfg_ff.threshold_sq     <= THRESH_SQ_RESET;
         cfg_ff.silence_limit    <= SILENCE_RESET;
         cfg_ff.min_segment      <= MIN_SEG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/evss_front.sv @@
// ----------------------------------------------------------------------------
// evss_front
// Request register, mono downmix and squared magnitude register.
// ----------------------------------------------------------------------------
module evss_front import evss_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               req_valid,
   input  req_payload_type    req_data,
   input  logic [1:0]         channel_count,
   output logic               sq_valid,
   output logic [SQ_BITS-1:0] sq,
   output logic               sq_last
);

   logic                          in_valid_ff;
   req_payload_type               in_data_ff;
   logic                          sq_valid_ff;
   logic [SQ_BITS-1:0]            sq_ff;
   logic [SQ_BITS-1:0]            sq_in;
   logic                          sq_last_ff;
   logic signed [SAMPLE_BITS:0]   pair_sum;
   logic signed [SAMPLE_BITS-1:0] mono;
   logic [SAMPLE_BITS-1:0]        mag;
   logic [2*SAMPLE_BITS-1:0]      prod;

   assign sq_valid = sq_valid_ff;
   assign sq       = sq_ff;
   assign sq_last  = sq_last_ff;

   // mono sample: floor of the average with two channels
   always_comb begin
      pair_sum = {in_data_ff.sample_first[SAMPLE_BITS-1], in_data_ff.sample_first}
               + {in_data_ff.sample_second[SAMPLE_BITS-1], in_data_ff.sample_second};
      mono     = channel_count[1] ? pair_sum[SAMPLE_BITS:1] : in_data_ff.sample_first;
      mag      = mono[SAMPLE_BITS-1] ? (~mono + SAMPLE_BITS'(1)) : mono;
      prod     = mag * mag;
      sq_in    = prod[SQ_BITS-1:0];
   end

   // valid bits of both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         sq_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
         sq_valid_ff <= in_valid_ff;
      end
   end

   // payload of both stages
   always_ff @(posedge clock) begin
      if (advance) begin
         in_data_ff <= req_data;
         sq_ff      <= sq_in;
         sq_last_ff <= in_data_ff.frame_last;
      end
   end

endmodule

@@ hdl/evss_frame_acc.sv @@
// ----------------------------------------------------------------------------
// evss_frame_acc
// Frame energy accumulation against the threshold and frame end detection.
// ----------------------------------------------------------------------------
module evss_frame_acc import evss_pkg::*; #(
   parameter int MAX_FRAME = MAX_FRAME_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          sq_valid,
   input  logic [SQ_BITS-1:0]            sq,
   input  logic                          sq_last,
   input  cfg_type                       cfg,
   output logic                          frm_valid,
   output logic                          frm_speech,
   output logic [$clog2(MAX_FRAME+1)-1:0] frm_n
);

   localparam int FrameBits = $clog2(MAX_FRAME + 1);
   localparam int DiffBits  = SQ_BITS + 1 + $clog2(MAX_FRAME);

   // running sum of (square - threshold square); speech when not negative
   logic signed [DiffBits-1:0] diff_ff;
   logic signed [DiffBits-1:0] diff_in;
   logic signed [DiffBits-1:0] term;
   logic signed [DiffBits-1:0] diff_sum;
   logic [FrameBits-1:0]       count_ff;
   logic [FrameBits-1:0]       count_in;
   logic [FrameBits-1:0]       count_next;
   logic                       frame_end;
   logic                       frm_valid_ff;
   logic                       frm_valid_in;
   logic                       frm_speech_ff;
   logic                       frm_speech_in;
   logic [FrameBits-1:0]       frm_n_ff;

   assign frm_valid  = frm_valid_ff;
   assign frm_speech = frm_speech_ff;
   assign frm_n      = frm_n_ff;

   // accumulate and classify at the frame end
   always_comb begin
      term       = signed'(DiffBits'(sq)) - signed'(DiffBits'(cfg.threshold_sq));
      diff_sum   = diff_ff + term;
      count_next = count_ff + FrameBits'(1);
      frame_end  = sq_last || (count_next == FrameBits'(MAX_FRAME));
      diff_in       = diff_ff;
      count_in      = count_ff;
      frm_valid_in  = 1'b0;
      frm_speech_in = !cfg.detector_enabled || !diff_sum[DiffBits-1];
      if (sq_valid) begin
         if (frame_end) begin
            diff_in      = '0;
            count_in     = '0;
            frm_valid_in = 1'b1;
         end else begin
            diff_in  = diff_sum;
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_ff      <= '0;
         count_ff     <= '0;
         frm_valid_ff <= 1'b0;
      end else if (advance) begin
         diff_ff      <= diff_in;
         count_ff     <= count_in;
         frm_valid_ff <= frm_valid_in;
      end
   end

   // frame result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         frm_speech_ff <= frm_speech_in;
         frm_n_ff      <= count_next;
      end
   end

   // frame never grows past its maximum
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < FrameBits'(MAX_FRAME))
      else $error("frame sample count out of range");

   // a finished frame holds at least one sample
   a_frame_nonempty: assert property (@(posedge clock) disable iff (reset)
      frm_valid_ff |-> (frm_n_ff != '0))
      else $error("empty frame reported");

endmodule

@@ hdl/evss_segmenter.sv @@
// ----------------------------------------------------------------------------
// evss_segmenter
// Segment and silence counters, end of segment decision and result register.
// ----------------------------------------------------------------------------
module evss_segmenter import evss_pkg::*; #(
   parameter int MAX_FRAME  = MAX_FRAME_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           frm_valid,
   input  logic                           frm_speech,
   input  logic [$clog2(MAX_FRAME+1)-1:0] frm_n,
   input  cfg_type                        cfg,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output rsp_payload_type                rsp_data,
   output logic                           advance
);

   localparam int SumBits = COUNT_BITS + 1;
   localparam int CmpBits = (COUNT_BITS > CFG_COUNT_BITS) ? COUNT_BITS : CFG_COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

   logic [COUNT_BITS-1:0] seg_ff;
   logic [COUNT_BITS-1:0] seg_in;
   logic [COUNT_BITS-1:0] sil_ff;
   logic [COUNT_BITS-1:0] sil_in;
   logic [SumBits-1:0]    seg_sum;
   logic [SumBits-1:0]    sil_sum;
   logic [COUNT_BITS-1:0] seg_sat;
   logic [COUNT_BITS-1:0] sil_sat;
   logic [COUNT_BITS-1:0] reported;
   seg_event_type         seg_event;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_data_ff;
   rsp_payload_type       rsp_data_in;

   // whole pipeline moves while the result register is free or drained
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // saturating counter updates
   always_comb begin
      seg_sum = SumBits'(seg_ff) + SumBits'(frm_n);
      sil_sum = SumBits'(sil_ff) + SumBits'(frm_n);
      seg_sat = seg_sum[COUNT_BITS] ? CountMax : seg_sum[COUNT_BITS-1:0];
      sil_sat = sil_sum[COUNT_BITS] ? CountMax : sil_sum[COUNT_BITS-1:0];
   end

   // segment decision for one finished frame
   always_comb begin
      seg_in    = seg_ff;
      sil_in    = sil_ff;
      reported  = '0;
      seg_event = EVENT_NONE;
      if (frm_speech) begin
         seg_in   = seg_sat;
         sil_in   = '0;
         reported = seg_sat;
      end else if (seg_ff != '0) begin
         seg_in   = seg_sat;
         sil_in   = sil_sat;
         reported = seg_sat;
         if (CmpBits'(sil_sat) >= CmpBits'(cfg.silence_limit)) begin
            seg_event = (CmpBits'(seg_sat) >= CmpBits'(cfg.min_segment)) ?
                        EVENT_ACCEPTED : EVENT_DISCARDED;
            seg_in    = '0;
            sil_in    = '0;
         end
      end
      rsp_data_in.frame_is_speech = frm_speech;
      rsp_data_in.segment_event   = seg_event;
      rsp_data_in.segment_samples = CFG_COUNT_BITS'(reported);
      rsp_data_in.segment_open    = (seg_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= '0;
         sil_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= frm_valid;
         if (frm_valid) begin
            seg_ff <= seg_in;
            sil_ff <= sil_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance && frm_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a closing event leaves no segment open and only follows a silent frame
   a_event_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.segment_event != EVENT_NONE))
      |-> (!rsp_data_ff.segment_open && !rsp_data_ff.frame_is_speech))
      else $error("segment event with segment still open");

   // silence is only counted inside a segment
   a_silence_in_segment: assert property (@(posedge clock) disable iff (reset)
      (sil_ff != '0) |-> (seg_ff != '0))
      else $error("silence counted outside a segment");

   // a silent frame with no segment reports zero length
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.segment_open
         && (rsp_data_ff.segment_event == EVENT_NONE))
      |-> (rsp_data_ff.segment_samples == '0))
      else $error("nonzero length reported with no segment");

endmodule

@@ hdl/energy_vad_speech_segmenter.sv @@
// ----------------------------------------------------------------------------
// energy_vad_speech_segmenter
// Energy based voice activity detection and speech segmentation.
//
//   channel   direction  payload                                   note
//   req_chan  in         sample_first, sample_second, frame_last   one sample
//   rsp_chan  out        frame_is_speech, segment_event,           one per frame
//                        segment_samples, segment_open
//   csr_chan  in         index, value                              always ready
//
// One request is taken every cycle while the pipeline advances; a frame
// result is valid on rsp_chan once the request that ends the frame has
// passed the request, square and frame registers, then the result register.
// Reset restores the register defaults.
// While a result waits on rsp_chan the whole pipeline holds and req_chan is
// not ready; an empty result register lets it run on.
// ----------------------------------------------------------------------------
module energy_vad_speech_segmenter import evss_pkg::*; #(
   parameter int MAX_FRAME  = MAX_FRAME_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   evss_req_if.sink       req_chan,
   evss_rsp_if.source     rsp_chan,
   evss_csr_if.sink       csr_chan
);

   localparam int FrameBits = $clog2(MAX_FRAME + 1);

   cfg_type              cfg;
   logic                 advance;
   logic                 sq_valid;
   logic [SQ_BITS-1:0]   sq;
   logic                 sq_last;
   logic                 frm_valid;
   logic                 frm_speech;
   logic [FrameBits-1:0] frm_n;

   assign req_chan.ready = advance;

   // configuration registers
   evss_cfg_regs u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_chan.valid),
      .wr_data  (csr_chan.data),
      .wr_ready (csr_chan.ready),
      .cfg      (cfg)
   );

   // request register and squared mono sample
   evss_front u_front (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .req_valid     (req_chan.valid),
      .req_data      (req_chan.data),
      .channel_count (cfg.channel_count),
      .sq_valid      (sq_valid),
      .sq            (sq),
      .sq_last       (sq_last)
   );

   // frame energy and classification
   evss_frame_acc #(
      .MAX_FRAME (MAX_FRAME)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .sq_valid   (sq_valid),
      .sq         (sq),
      .sq_last    (sq_last),
      .cfg        (cfg),
      .frm_valid  (frm_valid),
      .frm_speech (frm_speech),
      .frm_n      (frm_n)
   );

   // segment tracking and result register
   evss_segmenter #(
      .MAX_FRAME  (MAX_FRAME),
      .COUNT_BITS (COUNT_BITS)
   ) u_segment (
      .clock      (clock),
      .reset      (reset),
      .frm_valid  (frm_valid),
      .frm_speech (frm_speech),
      .frm_n      (frm_n),
      .cfg        (cfg),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_data   (rsp_chan.data),
      .advance    (advance)
   );

endmodule
